// ===== hw/rtl/atps_pkg.sv =====
// atps_pkg: shared constants, types and helper functions of the adaptive tx power select block
// used by the channel interfaces and the top level; depends on nothing
`default_nettype none

package atps_pkg;

    // attempt table geometry
    localparam int ATTEMPT_SLOTS = 8;
    localparam int SLOT_IDX_W    = (ATTEMPT_SLOTS > 1) ? $clog2(ATTEMPT_SLOTS) : 1;
    localparam int SLOT_CNT_W    = $clog2(ATTEMPT_SLOTS + 1);

    // payload widths
    localparam int NODE_W   = 32;
    localparam int PKT_W    = 32;
    localparam int SNR_W    = 8;
    localparam int BEST_W   = 7;
    localparam int PWR_W    = 6;
    localparam int TALLY_W  = 8;
    localparam int CAP_W    = 5;
    localparam int CALC_W   = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_TX_POWER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_CAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LICENSED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_POWER = 2'd3;

    // sequencer states
    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
    localparam logic [STATE_W-1:0] ST_SCAN = 2'd1;
    localparam logic [STATE_W-1:0] ST_CALC = 2'd2;
    localparam logic [STATE_W-1:0] ST_DONE = 2'd3;

    // power limits and retry steps
    localparam logic signed [CALC_W-1:0] PWR_MIN      = -8'sd9;
    localparam logic signed [CALC_W-1:0] PWR_FLOOR_DB = 8'sd4;
    localparam logic signed [CALC_W-1:0] RETRY_ONE    = 8'sd2;
    localparam logic signed [CALC_W-1:0] RETRY_MANY   = 8'sd4;
    localparam logic [TALLY_W-1:0]       TALLY_MAX    = 8'd255;

    // snr thresholds in quarter dB (15, 10, 6, 3, -7, -3 dB)
    localparam logic signed [SNR_W-1:0] SNR_Q_15DB  = 8'sd60;
    localparam logic signed [SNR_W-1:0] SNR_Q_10DB  = 8'sd40;
    localparam logic signed [SNR_W-1:0] SNR_Q_6DB   = 8'sd24;
    localparam logic signed [SNR_W-1:0] SNR_Q_3DB   = 8'sd12;
    localparam logic signed [SNR_W-1:0] SNR_Q_M7DB  = -8'sd28;
    localparam logic signed [SNR_W-1:0] SNR_Q_M3DB  = -8'sd12;

    // one attempt table entry
    typedef struct packed {
        logic [NODE_W-1:0]  sender;
        logic [PKT_W-1:0]   packet;
        logic [TALLY_W-1:0] tally;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // stepped power delta from link snr
    function automatic logic signed [CALC_W-1:0] snr_step(input logic signed [SNR_W-1:0] q);
        logic signed [CALC_W-1:0] d;
        if (q >= SNR_Q_15DB)       d = -8'sd6;
        else if (q >= SNR_Q_10DB)  d = -8'sd4;
        else if (q >= SNR_Q_6DB)   d = -8'sd2;
        else if (q >= SNR_Q_3DB)   d = -8'sd1;
        else if (q <= SNR_Q_M7DB)  d = 8'sd4;
        else if (q <= SNR_Q_M3DB)  d = 8'sd2;
        else                       d = 8'sd0;
        return d;
    endfunction

    // clamp to minimum power first, then to the ceiling
    function automatic logic signed [CALC_W-1:0] limit_power(
        input logic signed [CALC_W-1:0] v,
        input logic signed [CALC_W-1:0] ceil_pwr
    );
        logic signed [CALC_W-1:0] r;
        if (v < PWR_MIN)        r = PWR_MIN;
        else if (v > ceil_pwr)  r = ceil_pwr;
        else                    r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/atps_req_if.sv =====
// atps_req_if: valid/ready channel carrying one transmit request beat
// depends on atps_pkg for payload widths
`default_nettype none

interface atps_req_if;
    import atps_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [NODE_W-1:0]        source_node;
    logic [PKT_W-1:0]         packet_id;
    logic                     dest_is_unicast;
    logic signed [SNR_W-1:0]  direct_snr;
    logic [BEST_W-1:0]        best_neighbor_snr;

    modport source (
        output valid, source_node, packet_id, dest_is_unicast, direct_snr, best_neighbor_snr,
        input  ready
    );
    modport sink (
        input  valid, source_node, packet_id, dest_is_unicast, direct_snr, best_neighbor_snr,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/atps_res_if.sv =====
// atps_res_if: valid/ready channel carrying one power selection result beat
// depends on atps_pkg for payload widths
`default_nettype none

interface atps_res_if;
    import atps_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PWR_W-1:0]  sel_power;
    logic [TALLY_W-1:0]       attempt_count;

    modport source (
        output valid, sel_power, attempt_count,
        input  ready
    );
    modport sink (
        input  valid, sel_power, attempt_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/atps_ram.sv =====
// atps_ram: generic single write port, single read port ram with registered read data
// standalone, no package dependency
`default_nettype none

module atps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/adaptive_tx_power_select.sv =====
// adaptive_tx_power_select: the time from an accepted request to result valid grows with the
// attempt slot the packet hits, and is longest on a miss; a new request is taken only after the
// result of the last one has been registered. This is set by the slot-by-slot search of the
// attempt table ram, one entry read per cycle.
// Reset (synchronous) clears the control and configuration registers, marks every table slot
// invalid (reads as zero) and sets the applied power to zero; no clearing pass is needed.
`default_nettype none

module adaptive_tx_power_select (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [atps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [atps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    atps_req_if.sink                             i_req,
    atps_res_if.source                           o_res
);
    import atps_pkg::*;

    // configuration registers
    logic signed [PWR_W-1:0] r_tx_setting;
    logic [CAP_W-1:0]        r_region_cap;
    logic                    r_licensed;

    // sequencer and captured request
    logic [STATE_W-1:0]      r_state, n_state;
    logic [NODE_W-1:0]       r_sender;
    logic [PKT_W-1:0]        r_packet;
    logic                    r_unicast;
    logic signed [SNR_W-1:0] r_direct;
    logic [BEST_W-1:0]       r_best;

    // table scan
    logic [SLOT_CNT_W-1:0]   r_idx;
    logic [SLOT_IDX_W-1:0]   r_pidx;
    logic                    r_pend;
    logic [ATTEMPT_SLOTS-1:0] r_valid;
    logic [TALLY_W-1:0]      r_tries;

    // power pipeline
    logic signed [CALC_W-1:0] r_ceil;
    logic signed [CALC_W-1:0] r_target;
    logic signed [PWR_W-1:0]  r_applied;

    // output register
    logic                    r_out_valid;
    logic signed [PWR_W-1:0] r_out_power;
    logic [TALLY_W-1:0]      r_out_count;

    // ram port signals
    logic                    ram_we;
    logic [SLOT_IDX_W-1:0]   ram_waddr;
    t_entry                  ram_wdata;
    logic [ENTRY_W-1:0]      ram_rdata;
    t_entry                  slot_entry;

    logic                    req_beat;
    logic                    res_beat;
    logic                    slot_hit;
    logic                    scan_last;
    logic [TALLY_W-1:0]      hit_tally;
    logic                    done_fire;

    logic signed [CALC_W-1:0] calc_ceil;
    logic signed [CALC_W-1:0] calc_target;
    logic signed [CALC_W-1:0] final_power;

    assign req_beat    = i_req.valid && i_req.ready;
    assign res_beat    = o_res.valid && o_res.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    // attempt table storage
    atps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ATTEMPT_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[SLOT_IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // slot that was never written reads as cleared
    assign slot_entry = r_valid[r_pidx] ? t_entry'(ram_rdata) : '0;
    assign slot_hit   = r_pend && (slot_entry.sender == r_sender)
                        && (slot_entry.packet == r_packet);
    assign scan_last  = r_pend && (r_pidx == SLOT_IDX_W'(ATTEMPT_SLOTS - 1));
    assign hit_tally  = (slot_entry.tally == TALLY_MAX) ? TALLY_MAX
                        : slot_entry.tally + TALLY_W'(1);

    // write back: bump tally on a hit, overwrite slot zero on a miss
    always_comb begin
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata.sender = r_sender;
        ram_wdata.packet = r_packet;
        ram_wdata.tally  = '0;
        if (r_state == ST_SCAN) begin
            if (slot_hit) begin
                ram_we          = 1'b1;
                ram_waddr       = r_pidx;
                ram_wdata.tally = hit_tally;
            end else if (scan_last) begin
                ram_we = 1'b1;
            end
        end
    end

    // ceiling and snr adjusted target
    always_comb begin
        logic signed [CALC_W-1:0] base;
        logic signed [CALC_W-1:0] cap_s;
        logic signed [SNR_W-1:0]  snr;
        logic                     have_snr;
        logic signed [CALC_W-1:0] stepped;
        logic signed [CALC_W-1:0] floor_pwr;
        cap_s = CALC_W'({1'b0, r_region_cap});
        if (r_tx_setting != '0)       base = CALC_W'(r_tx_setting);
        else if (r_region_cap != '0)  base = cap_s;
        else                          base = CALC_W'(r_applied);
        if (!r_licensed && (r_region_cap != '0) && (cap_s < base)) calc_ceil = cap_s;
        else                                                       calc_ceil = base;

        have_snr = 1'b0;
        snr      = '0;
        if (r_unicast && (r_direct != '0)) begin
            have_snr = 1'b1;
            snr      = r_direct;
        end else if (r_best != '0) begin
            have_snr = 1'b1;
            snr      = SNR_W'({1'b0, r_best});
        end

        stepped   = limit_power(calc_ceil + snr_step(snr), calc_ceil);
        floor_pwr = calc_ceil - PWR_FLOOR_DB;
        if (!have_snr)               calc_target = calc_ceil;
        else if (stepped < floor_pwr) calc_target = floor_pwr;
        else                          calc_target = stepped;
    end

    // retry step-up
    always_comb begin
        if (r_tries == TALLY_W'(1))       final_power = limit_power(r_target + RETRY_ONE, r_ceil);
        else if (r_tries != '0)           final_power = limit_power(r_target + RETRY_MANY, r_ceil);
        else                              final_power = r_target;
    end

    assign done_fire = (r_state == ST_DONE) && (!r_out_valid || o_res.ready);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (req_beat) n_state = ST_SCAN;
            ST_SCAN: if (slot_hit || scan_last) n_state = ST_CALC;
            ST_CALC: n_state = ST_DONE;
            ST_DONE: if (done_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // configuration writes; start power writes are ignored, reset sets the applied power to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_setting <= '0;
            r_region_cap <= '0;
            r_licensed   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TX_POWER:   r_tx_setting <= i_cfg_data[PWR_W-1:0];
                REG_REGION_CAP: r_region_cap <= i_cfg_data[CAP_W-1:0];
                REG_LICENSED:   r_licensed   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_pend      <= 1'b0;
            r_idx       <= '0;
            r_applied   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            // read issue, one slot per cycle
            if (req_beat) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                if (r_idx < SLOT_CNT_W'(ATTEMPT_SLOTS)) begin
                    r_idx  <= r_idx + SLOT_CNT_W'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
            // result register
            if (done_fire) begin
                r_out_valid <= 1'b1;
                r_applied   <= final_power[PWR_W-1:0];
            end else if (res_beat) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_beat) begin
            r_sender  <= i_req.source_node;
            r_packet  <= i_req.packet_id;
            r_unicast <= i_req.dest_is_unicast;
            r_direct  <= i_req.direct_snr;
            r_best    <= i_req.best_neighbor_snr;
        end
        if (r_state == ST_SCAN) begin
            r_pidx <= r_idx[SLOT_IDX_W-1:0];
            if (slot_hit)       r_tries <= hit_tally;
            else if (scan_last) r_tries <= '0;
        end
        if (r_state == ST_CALC) begin
            r_ceil   <= calc_ceil;
            r_target <= calc_target;
        end
        if (done_fire) begin
            r_out_power <= final_power[PWR_W-1:0];
            r_out_count <= r_tries;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.sel_power     = r_out_power;
    assign o_res.attempt_count = r_out_count;

    // table is written back only while scanning
    a_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_SCAN))
        else $error("attempt table written outside scan");

    // a write to slot zero marks it valid on the next edge
    a_valid_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (ram_waddr == '0)) |=> r_valid[0])
        else $error("slot zero not marked valid after write");

    // no request taken while one is in flight
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_req.ready)
        else $error("request accepted while busy");

    // result beat held steady while stalled
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |=> (o_res.valid && $stable(o_res.sel_power)
                                           && $stable(o_res.attempt_count)))
        else $error("result beat changed while stalled");

endmodule

`default_nettype wire

// ===== tb/tb_adaptive_tx_power_select.sv =====
`timescale 1ns / 1ps
// tb_adaptive_tx_power_select: self-checking testbench for the adaptive tx power select block
// drives request beats and register writes, predicts power and attempt count per request
// depends on atps_pkg, atps_req_if, atps_res_if and adaptive_tx_power_select

module tb_adaptive_tx_power_select;
    import atps_pkg::*;

    // one request beat as seen on the input channel
    typedef struct {
        logic [NODE_W-1:0]       sender;
        logic [PKT_W-1:0]        packet;
        logic                    unicast;
        logic signed [SNR_W-1:0] direct;
        logic [BEST_W-1:0]       best;
    } t_req_beat;

    // one expected result beat
    typedef struct {
        logic signed [PWR_W-1:0] sel_power;
        logic [TALLY_W-1:0]      attempts;
    } t_power_beat;

    // tracks attempt table, applied power and registers; checks result beats in order
    class t_power_tracker;
        logic [NODE_W-1:0]       slot_sender [ATTEMPT_SLOTS];
        logic [PKT_W-1:0]        slot_packet [ATTEMPT_SLOTS];
        logic [TALLY_W-1:0]      slot_tally  [ATTEMPT_SLOTS];
        logic signed [PWR_W-1:0] power_setting;
        logic [CAP_W-1:0]        cap_limit;
        logic                    lic_flag;
        logic signed [PWR_W-1:0] start_level;
        int                      applied;
        t_power_beat             expected_power[$];
        int                      mismatch_count;

        function new();
            for (int i = 0; i < ATTEMPT_SLOTS; i++) begin
                slot_sender[i] = '0;
                slot_packet[i] = '0;
                slot_tally[i]  = '0;
            end
            power_setting  = '0;
            cap_limit      = '0;
            lic_flag       = 1'b0;
            start_level    = '0;
            applied        = 0;
            mismatch_count = 0;
        endfunction

        // start power is recorded but does not enter the prediction
        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TX_POWER:    power_setting = data;
                REG_REGION_CAP:  cap_limit = data[CAP_W-1:0];
                REG_LICENSED:    lic_flag = data[0];
                REG_START_POWER: start_level = data;
                default: ;
            endcase
        endfunction

        function int clamp_power(int v, int ceiling);
            if (v < -9)
                return -9;
            if (v > ceiling)
                return ceiling;
            return v;
        endfunction

        function void note_request(t_req_beat r);
            int          tries;
            int          ceiling;
            int          target;
            int          snr;
            int          delta;
            bit          have_snr;
            bit          hit;
            t_power_beat e;

            // attempt table: first matching slot counts up, a miss takes slot 0
            hit   = 1'b0;
            tries = 0;
            for (int i = 0; i < ATTEMPT_SLOTS && !hit; i++) begin
                if (slot_sender[i] == r.sender && slot_packet[i] == r.packet) begin
                    hit = 1'b1;
                    if (slot_tally[i] != 8'd255)
                        slot_tally[i] = slot_tally[i] + 8'd1;
                    tries = slot_tally[i];
                end
            end
            if (!hit) begin
                slot_sender[0] = r.sender;
                slot_packet[0] = r.packet;
                slot_tally[0]  = '0;
            end

            // power ceiling
            if (power_setting != 0)
                ceiling = int'(power_setting);
            else if (cap_limit != 0)
                ceiling = int'(cap_limit);
            else
                ceiling = applied;
            if (!lic_flag && cap_limit != 0 && int'(cap_limit) < ceiling)
                ceiling = int'(cap_limit);

            // link snr selection and stepped delta
            target   = ceiling;
            have_snr = 1'b0;
            snr      = 0;
            if (r.unicast && r.direct != 0) begin
                snr      = int'(r.direct);
                have_snr = 1'b1;
            end else if (r.best != 0) begin
                snr      = int'(r.best);
                have_snr = 1'b1;
            end
            if (have_snr) begin
                if (snr >= 60)        delta = -6;
                else if (snr >= 40)   delta = -4;
                else if (snr >= 24)   delta = -2;
                else if (snr >= 12)   delta = -1;
                else if (snr <= -28)  delta = 4;
                else if (snr <= -12)  delta = 2;
                else                  delta = 0;
                target = clamp_power(ceiling + delta, ceiling);
                if (target < ceiling - 4)
                    target = ceiling - 4;
            end

            // retry boost
            if (tries == 1)
                target = clamp_power(target + 2, ceiling);
            else if (tries >= 2)
                target = clamp_power(target + 4, ceiling);

            applied     = target;
            e.sel_power = target[PWR_W-1:0];
            e.attempts  = tries[TALLY_W-1:0];
            expected_power = {expected_power, e};
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("%0t ns mismatch: %s", $time, what);
        endtask

        task check_result(logic signed [PWR_W-1:0] pwr, logic [TALLY_W-1:0] cnt);
            t_power_beat e;
            if (expected_power.size() == 0) begin
                report_mismatch($sformatf("result beat power %0d count %0d with none pending",
                                          pwr, cnt));
            end else begin
                e = expected_power[0];
                expected_power.delete(0);
                if (pwr !== e.sel_power)
                    report_mismatch($sformatf("power got %0d want %0d", pwr, e.sel_power));
                if (cnt !== e.attempts)
                    report_mismatch($sformatf("attempt_count got %0d want %0d",
                                              cnt, e.attempts));
            end
        endtask

        function int outstanding();
            return expected_power.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    atps_req_if req_ch ();
    atps_res_if res_ch ();

    t_power_tracker tracker = new();

    int burst_left = 0;

    adaptive_tx_power_select u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // beat monitor on both channels
    always @(posedge i_clk) begin
        t_req_beat r;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready)
                tracker.check_result(res_ch.sel_power, res_ch.attempt_count);
            if (req_ch.valid && req_ch.ready) begin
                r.sender  = req_ch.source_node;
                r.packet  = req_ch.packet_id;
                r.unicast = req_ch.dest_is_unicast;
                r.direct  = req_ch.direct_snr;
                r.best    = req_ch.best_neighbor_snr;
                tracker.note_request(r);
            end
        end
    end

    // result stall pattern: steps through four ready modes in turn
    initial begin
        int unsigned cyc;
        cyc = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            case ((cyc / 64) % 4)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       res_ch.ready <= ($urandom_range(0, 9) < 4);
                default: res_ch.ready <= ((cyc % 7) >= 3);
            endcase
        end
    end

    // one request beat, sender idles in bursts with random gaps
    task automatic send_request(input logic [NODE_W-1:0] sender, input logic [PKT_W-1:0] packet,
                                input logic unicast, input logic signed [SNR_W-1:0] direct,
                                input logic [BEST_W-1:0] best);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid             <= 1'b1;
        req_ch.source_node       <= sender;
        req_ch.packet_id         <= packet;
        req_ch.dest_is_unicast   <= unicast;
        req_ch.direct_snr        <= direct;
        req_ch.best_neighbor_snr <= best;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // stop sending and wait until every result beat is in
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (tracker.outstanding() > 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // write all four registers back to back, block idle
    task automatic apply_setting(input logic signed [PWR_W-1:0] pwr, input logic [CAP_W-1:0] cap,
                                 input logic lic, input logic signed [PWR_W-1:0] start);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0]  regs [4];
        regs[0] = REG_TX_POWER;    vals[0] = pwr;
        regs[1] = REG_REGION_CAP;  vals[1] = CFG_DATA_W'(cap);
        regs[2] = REG_LICENSED;    vals[2] = CFG_DATA_W'(lic);
        regs[3] = REG_START_POWER; vals[3] = start;
        for (int i = 0; i < 4; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            tracker.set_register(regs[i], vals[i]);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic signed [SNR_W-1:0]  snr_pts [14];
        logic signed [PWR_W-1:0]  set_pwr [8];
        logic [CAP_W-1:0]         set_cap [8];
        logic                     set_lic [8];
        logic signed [PWR_W-1:0]  set_start [8];
        logic [NODE_W-1:0]        pool_sender [2];
        logic [PKT_W-1:0]         pool_packet [2];
        logic [NODE_W-1:0]        s;
        logic [PKT_W-1:0]         p;
        logic signed [SNR_W-1:0]  d;
        logic [BEST_W-1:0]        b;
        int                       pick;
        int                       k;

        i_rst_n                  <= 1'b0;
        i_cfg_we                 <= 1'b0;
        i_cfg_idx                <= '0;
        i_cfg_data               <= '0;
        req_ch.valid             <= 1'b0;
        req_ch.source_node       <= '0;
        req_ch.packet_id         <= '0;
        req_ch.dest_is_unicast   <= 1'b0;
        req_ch.direct_snr        <= '0;
        req_ch.best_neighbor_snr <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, applied power chain as ceiling
        // cleared table slot hit by sender 0 packet 0
        send_request('0, '0, 1'b1, 8'sd0, 7'd0);
        // snr thresholds on both sides, retries in groups of four
        snr_pts = '{8'sd60, 8'sd59, 8'sd40, 8'sd39, 8'sd24, 8'sd23, 8'sd12, 8'sd11,
                    -8'sd11, -8'sd12, -8'sd27, -8'sd28, 8'sd127, -8'sd128};
        for (int i = 0; i < 14; i++)
            send_request('1, PKT_W'(i / 4), 1'b1, snr_pts[i], 7'd0);
        // broadcast falls back to best neighbor snr
        send_request(32'h0000_1234, 32'd7, 1'b0, -8'sd50, 7'd127);
        send_request(32'h0000_1234, 32'd7, 1'b0, 8'sd5, 7'd1);
        send_request(32'h0000_1234, 32'd7, 1'b0, 8'sd0, 7'd0);
        send_request(32'h0000_1234, 32'd8, 1'b1, 8'sd0, 7'd40);
        // sender 0 packet 0 now hits a cleared slot past slot 0
        send_request('0, '0, 1'b0, 8'sd0, 7'd60);
        send_request('0, '0, 1'b1, -8'sd30, 7'd0);
        drain();

        // register settings per phase, extremes first
        set_pwr   = '{6'sd0, 6'sd30, 6'sd30, -6'sd32, 6'sd31, 6'sd0, -6'sd9, 6'sd0};
        set_cap   = '{5'd0, 5'd20, 5'd20, 5'd31, 5'd0, 5'd31, 5'd1, 5'd0};
        set_lic   = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
        set_start = '{6'sd0, -6'sd9, 6'sd30, 6'sd31, -6'sd32, 6'sd5, 6'sd0, 6'sd0};

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7)
                apply_setting(PWR_W'($urandom_range(0, 63)), CAP_W'($urandom_range(0, 31)),
                              1'($urandom_range(0, 1)), PWR_W'($urandom_range(0, 63)));
            else
                apply_setting(set_pwr[ph], set_cap[ph], set_lic[ph], set_start[ph]);
            for (int j = 0; j < 2; j++) begin
                pool_sender[j] = ($urandom_range(0, 3) == 0) ? '0 : NODE_W'($urandom);
                pool_packet[j] = PKT_W'($urandom);
            end
            for (int i = 0; i < 56; i++) begin
                // mostly repeated packets so retries and tally saturation are reached
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    s = '0;
                    p = '0;
                end else if (pick < 88) begin
                    k = $urandom_range(0, 1);
                    s = pool_sender[k];
                    p = pool_packet[k];
                end else begin
                    s = NODE_W'($urandom);
                    p = PKT_W'($urandom);
                end
                d = ($urandom_range(0, 3) == 0) ? '0 : SNR_W'($urandom);
                b = ($urandom_range(0, 3) == 0) ? '0 : BEST_W'($urandom);
                send_request(s, p, 1'($urandom_range(0, 1)), d, b);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
